### design/mfmt_pkg.sv
// Shared constants, codes and types for the multi-turn motor feedback tracker.
package mfmt_pkg;

    localparam int MOTOR_SLOTS     = 8;
    localparam int HOME_FRAME      = 50;

    localparam int SLOT_W   = 3;
    localparam int ID_W     = 11;
    localparam int ANGLE_W  = 13;
    localparam int ROUND_W  = 16;
    localparam int FCNT_W   = 6;
    localparam int RPM_W    = 16;
    localparam int ABS_W    = 40;
    localparam int VEL_W    = 32;
    localparam int SCALE_W  = 32;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [ID_W-1:0]    BASE_ID   = 11'h201;
    localparam logic [ANGLE_W-1:0] LOW_BAND  = 13'd2048;
    localparam logic [ANGLE_W-1:0] HIGH_BAND = 13'd6144;
    localparam logic [FCNT_W-1:0]  FCNT_MAX  = 6'd63;
    localparam logic [FCNT_W-1:0]  AZ_FRAME  = FCNT_W'(HOME_FRAME);

    localparam logic [SCALE_W-1:0] ANGLE_SCALE_ZERO_RST = 32'd9828776;
    localparam logic [SCALE_W-1:0] ANGLE_SCALE_ONE_RST  = 32'd5242880;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_ZERO_RST = 32'd223658837;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_ONE_RST  = 32'd119304647;

    typedef enum logic [2:0] {
        REG_PRESENT     = 3'd0,
        REG_REVERSE     = 3'd1,
        REG_HOME_MASK   = 3'd2,
        REG_TYPE        = 3'd3,
        REG_ANGLE_ZERO  = 3'd4,
        REG_ANGLE_ONE   = 3'd5,
        REG_SPEED_ZERO  = 3'd6,
        REG_SPEED_ONE   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_IGNORED = 2'd1,
        ST_UNREG   = 2'd2,
        ST_RESET   = 2'd3
    } status_t;

    typedef enum logic {
        OP_FEEDBACK = 1'b0,
        OP_ZERO     = 1'b1
    } op_t;

endpackage

### design/motor_feedback_multiturn_tracker_unit.sv
// Multi-turn motor feedback tracker: slot decode, turn counting, scaling, APB registers.
// Items pass the input register, then the result register. Throughput: one item
// per cycle unless m_ready stalls the result; per-slot state is updated as an item
// leaves the input register, so the next item sees it. Cycle time set by one 30x33
// and one 17x33 multiply. Reset (aresetn, synchronous, active low) clears per-slot
// state, valid flags and masks, and loads the default scales.
module motor_feedback_multiturn_tracker_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [mfmt_pkg::ID_W-1:0]          s_frame_id,
    input  logic                               s_is_extended,
    input  logic [mfmt_pkg::ANGLE_W-1:0]       s_angle_raw,
    input  logic signed [mfmt_pkg::RPM_W-1:0]  s_speed_rpm,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [mfmt_pkg::SLOT_W-1:0]        m_motor_slot,
    output logic signed [mfmt_pkg::ABS_W-1:0]  m_abs_angle,
    output logic signed [mfmt_pkg::VEL_W-1:0]  m_velocity,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mfmt_pkg::PADDR_W-1:0]       paddr,
    input  logic [mfmt_pkg::PDATA_W-1:0]       pwdata,
    output logic [mfmt_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int CNT_W  = 30;  // turns*8192 + angle difference, signed
    localparam int APROD_W = CNT_W + mfmt_pkg::SCALE_W + 1;
    localparam int VMUL_W  = mfmt_pkg::RPM_W + 1;
    localparam int VPROD_W = VMUL_W + mfmt_pkg::SCALE_W + 1;
    localparam int ASHR_W  = APROD_W + 1 - 16;
    localparam int VSHR_W  = VPROD_W + 1 - 16;

    // ---------------- configuration registers ----------------
    logic [mfmt_pkg::MOTOR_SLOTS-1:0] present_mask_reg, reverse_mask_reg;
    logic [mfmt_pkg::MOTOR_SLOTS-1:0] home_mask_reg, type_mask_reg;
    logic [mfmt_pkg::SCALE_W-1:0]     angle_scale_zero_reg, angle_scale_one_reg;
    logic [mfmt_pkg::SCALE_W-1:0]     speed_scale_zero_reg, speed_scale_one_reg;
    mfmt_pkg::reg_idx_t               cfg_idx;
    logic                             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = mfmt_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_mask_reg     <= '0;
            reverse_mask_reg     <= '0;
            home_mask_reg        <= '0;
            type_mask_reg        <= '0;
            angle_scale_zero_reg <= mfmt_pkg::ANGLE_SCALE_ZERO_RST;
            angle_scale_one_reg  <= mfmt_pkg::ANGLE_SCALE_ONE_RST;
            speed_scale_zero_reg <= mfmt_pkg::SPEED_SCALE_ZERO_RST;
            speed_scale_one_reg  <= mfmt_pkg::SPEED_SCALE_ONE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mfmt_pkg::REG_PRESENT:    present_mask_reg     <= pwdata[7:0];
                mfmt_pkg::REG_REVERSE:    reverse_mask_reg     <= pwdata[7:0];
                mfmt_pkg::REG_HOME_MASK:  home_mask_reg        <= pwdata[7:0];
                mfmt_pkg::REG_TYPE:       type_mask_reg        <= pwdata[7:0];
                mfmt_pkg::REG_ANGLE_ZERO: angle_scale_zero_reg <= pwdata;
                mfmt_pkg::REG_ANGLE_ONE:  angle_scale_one_reg  <= pwdata;
                mfmt_pkg::REG_SPEED_ZERO: speed_scale_zero_reg <= pwdata;
                mfmt_pkg::REG_SPEED_ONE:  speed_scale_one_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mfmt_pkg::REG_PRESENT:    prdata = {24'd0, present_mask_reg};
            mfmt_pkg::REG_REVERSE:    prdata = {24'd0, reverse_mask_reg};
            mfmt_pkg::REG_HOME_MASK:  prdata = {24'd0, home_mask_reg};
            mfmt_pkg::REG_TYPE:       prdata = {24'd0, type_mask_reg};
            mfmt_pkg::REG_ANGLE_ZERO: prdata = angle_scale_zero_reg;
            mfmt_pkg::REG_ANGLE_ONE:  prdata = angle_scale_one_reg;
            mfmt_pkg::REG_SPEED_ZERO: prdata = speed_scale_zero_reg;
            mfmt_pkg::REG_SPEED_ONE:  prdata = speed_scale_one_reg;
            default:                  prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic                              in_valid_reg;
    logic                              in_op_reg;
    logic [mfmt_pkg::ID_W-1:0]         in_id_reg;
    logic                              in_ext_reg;
    logic [mfmt_pkg::ANGLE_W-1:0]      in_raw_reg;
    logic signed [mfmt_pkg::RPM_W-1:0] in_rpm_reg;
    logic                              advance;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg  <= s_op;
            in_id_reg  <= s_frame_id;
            in_ext_reg <= s_is_extended;
            in_raw_reg <= s_angle_raw;
            in_rpm_reg <= s_speed_rpm;
        end
    end

    // ---------------- per-slot state ----------------
    logic [mfmt_pkg::ANGLE_W-1:0] last_angle_reg  [mfmt_pkg::MOTOR_SLOTS];
    logic [mfmt_pkg::ROUND_W-1:0] round_count_reg [mfmt_pkg::MOTOR_SLOTS];
    logic [mfmt_pkg::ANGLE_W-1:0] zero_angle_reg  [mfmt_pkg::MOTOR_SLOTS];
    logic [mfmt_pkg::FCNT_W-1:0]  frame_count_reg [mfmt_pkg::MOTOR_SLOTS];

    // ---------------- decode and compute ----------------
    logic [mfmt_pkg::ID_W-1:0]    id_off;
    logic                         in_range;
    logic [mfmt_pkg::SLOT_W-1:0]  slot;
    logic                         registered;
    logic                         is_zero_op;
    logic [mfmt_pkg::ANGLE_W-1:0] last_a, zero_a;
    logic [mfmt_pkg::ROUND_W-1:0] rc, rc_new;
    logic [mfmt_pkg::FCNT_W-1:0]  fc, fc_new;
    logic                         turn_up, turn_dn;
    logic                         rev, typ, home_now;
    logic signed [CNT_W-1:0]      counts, counts_dir;
    logic [mfmt_pkg::SCALE_W-1:0] a_scale, v_scale;
    logic signed [APROD_W-1:0]    a_prod;
    logic signed [APROD_W:0]      a_sum;
    logic signed [ASHR_W-1:0]     a_shr;
    logic signed [mfmt_pkg::ABS_W-1:0] a_sat;
    logic signed [VMUL_W-1:0]     rpm_dir;
    logic signed [VPROD_W-1:0]    v_prod;
    logic signed [VPROD_W:0]      v_sum;
    logic signed [VSHR_W-1:0]     v_shr;
    logic signed [mfmt_pkg::VEL_W-1:0] v_sat;

    assign id_off     = in_id_reg - mfmt_pkg::BASE_ID;
    assign in_range   = !in_ext_reg && (in_id_reg >= mfmt_pkg::BASE_ID)
                        && (id_off < mfmt_pkg::ID_W'(mfmt_pkg::MOTOR_SLOTS));
    assign slot       = id_off[mfmt_pkg::SLOT_W-1:0];
    assign registered = present_mask_reg[slot];
    assign is_zero_op = (mfmt_pkg::op_t'(in_op_reg) == mfmt_pkg::OP_ZERO);

    assign last_a = last_angle_reg[slot];
    assign zero_a = zero_angle_reg[slot];
    assign rc     = round_count_reg[slot];
    assign fc     = frame_count_reg[slot];

    // wrap crossings between the outer bands of the encoder range
    assign turn_up = (in_raw_reg < mfmt_pkg::LOW_BAND) && (last_a > mfmt_pkg::HIGH_BAND);
    assign turn_dn = (in_raw_reg > mfmt_pkg::HIGH_BAND) && (last_a < mfmt_pkg::LOW_BAND);
    assign rc_new  = rc + {{(mfmt_pkg::ROUND_W-1){turn_dn}}, turn_up | turn_dn};
    assign fc_new  = (fc < mfmt_pkg::FCNT_MAX) ? fc + 1'b1 : fc;

    assign rev      = reverse_mask_reg[slot];
    assign typ      = type_mask_reg[slot];
    assign home_now = home_mask_reg[slot] && (fc_new == mfmt_pkg::AZ_FRAME);

    assign counts = $signed({rc_new[mfmt_pkg::ROUND_W-1], rc_new, 13'd0})
                    + $signed({17'd0, in_raw_reg}) - $signed({17'd0, zero_a});
    assign counts_dir = rev ? -counts : counts;

    assign a_scale = typ ? angle_scale_one_reg : angle_scale_zero_reg;
    assign v_scale = typ ? speed_scale_one_reg : speed_scale_zero_reg;

    assign a_prod = counts_dir * $signed({1'b0, a_scale});
    assign a_sum  = APROD_W'(a_prod) + (APROD_W+1)'(32768);
    assign a_shr  = ASHR_W'(a_sum >>> 16);

    // saturate when the bits above the field are not a plain sign extension
    always_comb begin
        if (!a_shr[ASHR_W-1] && (a_shr[ASHR_W-2:mfmt_pkg::ABS_W-1] != '0)) begin
            a_sat = {1'b0, {(mfmt_pkg::ABS_W-1){1'b1}}};
        end else if (a_shr[ASHR_W-1] && (a_shr[ASHR_W-2:mfmt_pkg::ABS_W-1] != '1)) begin
            a_sat = {1'b1, {(mfmt_pkg::ABS_W-1){1'b0}}};
        end else begin
            a_sat = a_shr[mfmt_pkg::ABS_W-1:0];
        end
    end

    assign rpm_dir = rev ? -VMUL_W'(in_rpm_reg) : VMUL_W'(in_rpm_reg);
    assign v_prod  = rpm_dir * $signed({1'b0, v_scale});
    assign v_sum   = VPROD_W'(v_prod) + (VPROD_W+1)'(32768);
    assign v_shr   = VSHR_W'(v_sum >>> 16);

    always_comb begin
        if (!v_shr[VSHR_W-1] && (v_shr[VSHR_W-2:mfmt_pkg::VEL_W-1] != '0)) begin
            v_sat = {1'b0, {(mfmt_pkg::VEL_W-1){1'b1}}};
        end else if (v_shr[VSHR_W-1] && (v_shr[VSHR_W-2:mfmt_pkg::VEL_W-1] != '1)) begin
            v_sat = {1'b1, {(mfmt_pkg::VEL_W-1){1'b0}}};
        end else begin
            v_sat = v_shr[mfmt_pkg::VEL_W-1:0];
        end
    end

    // ---------------- state update ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mfmt_pkg::MOTOR_SLOTS; i++) begin
                last_angle_reg[i]  <= '0;
                round_count_reg[i] <= '0;
                zero_angle_reg[i]  <= '0;
                frame_count_reg[i] <= '0;
            end
        end else if (advance && in_range && registered) begin
            if (is_zero_op) begin
                round_count_reg[slot] <= '0;
                zero_angle_reg[slot]  <= last_a;
            end else begin
                last_angle_reg[slot]  <= in_raw_reg;
                frame_count_reg[slot] <= fc_new;
                if (home_now) begin
                    round_count_reg[slot] <= '0;
                    zero_angle_reg[slot]  <= in_raw_reg;
                end else begin
                    round_count_reg[slot] <= rc_new;
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic                              m_valid_reg;
    mfmt_pkg::status_t                 status_reg, status_next;
    logic [mfmt_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic signed [mfmt_pkg::ABS_W-1:0] abs_reg, abs_next;
    logic signed [mfmt_pkg::VEL_W-1:0] vel_reg, vel_next;

    always_comb begin
        status_next = mfmt_pkg::ST_IGNORED;
        slot_next   = '0;
        abs_next    = '0;
        vel_next    = '0;
        if (in_range) begin
            slot_next = slot;
            if (!registered) begin
                status_next = mfmt_pkg::ST_UNREG;
            end else if (is_zero_op) begin
                status_next = mfmt_pkg::ST_RESET;
            end else begin
                status_next = mfmt_pkg::ST_UPDATED;
                abs_next    = home_now ? '0 : a_sat;
                vel_next    = v_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            abs_reg    <= abs_next;
            vel_reg    <= vel_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_motor_slot = slot_reg;
    assign m_abs_angle  = abs_reg;
    assign m_velocity   = vel_reg;

`ifndef ASSERT_OFF
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input register item dropped while stalled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("item moved on without a result");

    a_nonupdate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != mfmt_pkg::ST_UPDATED) |-> (m_abs_angle == '0)
        && (m_velocity == '0))
        else $error("non-update result carries angle or velocity");

    a_ignored_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == mfmt_pkg::ST_IGNORED) |-> (m_motor_slot == '0))
        else $error("ignored frame reports a slot");
`endif

endmodule

### verif/multiturn_check.sv
// Multi-turn tracker checker: watches the ports, predicts each result and compares.
`timescale 1ns / 100ps

module multiturn_check (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_op,
    input  logic [mfmt_pkg::ID_W-1:0]           s_frame_id,
    input  logic                                s_is_extended,
    input  logic [mfmt_pkg::ANGLE_W-1:0]        s_angle_raw,
    input  logic signed [mfmt_pkg::RPM_W-1:0]   s_speed_rpm,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [1:0]                          m_status,
    input  logic [mfmt_pkg::SLOT_W-1:0]         m_motor_slot,
    input  logic signed [mfmt_pkg::ABS_W-1:0]   m_abs_angle,
    input  logic signed [mfmt_pkg::VEL_W-1:0]   m_velocity,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfmt_pkg::PADDR_W-1:0]        paddr,
    input  logic [mfmt_pkg::PDATA_W-1:0]        pwdata,
    input  logic                                pready,
    output int                                  mismatch_count,
    output int                                  in_flight
);

    localparam longint TURN_COUNTS = 8192;

    typedef struct packed {
        mfmt_pkg::status_t                  status;
        logic [mfmt_pkg::SLOT_W-1:0]        slot;
        logic signed [mfmt_pkg::ABS_W-1:0]  angle;
        logic signed [mfmt_pkg::VEL_W-1:0]  vel;
    } shaft_result_t;

    // register copies
    logic [7:0]                   present_m, reverse_m, autozero_m, type_m;
    logic [mfmt_pkg::SCALE_W-1:0] ang_scale [2];
    logic [mfmt_pkg::SCALE_W-1:0] spd_scale [2];

    // per-slot tracking state
    logic [mfmt_pkg::ANGLE_W-1:0] last_ang  [mfmt_pkg::MOTOR_SLOTS];
    logic [mfmt_pkg::ROUND_W-1:0] turn_cnt  [mfmt_pkg::MOTOR_SLOTS];
    logic [mfmt_pkg::ANGLE_W-1:0] zero_ang  [mfmt_pkg::MOTOR_SLOTS];
    logic [mfmt_pkg::FCNT_W-1:0]  frame_cnt [mfmt_pkg::MOTOR_SLOTS];

    shaft_result_t shaft_results [$];
    int            errs;

    // round half up, drop 16 fraction bits, clamp to the field width
    function automatic longint round_saturate(longint prod, int bits);
        longint q;
        longint lim;
        q   = (prod + 64'sd32768) >>> 16;
        lim = longint'(1) <<< (bits - 1);
        if (q > lim - 1) q = lim - 1;
        if (q < -lim) q = -lim;
        return q;
    endfunction

    function automatic shaft_result_t track_frame(mfmt_pkg::op_t op,
                                                  logic [mfmt_pkg::ID_W-1:0] fid,
                                                  logic ext,
                                                  logic [mfmt_pkg::ANGLE_W-1:0] raw,
                                                  logic signed [mfmt_pkg::RPM_W-1:0] rpm);
        shaft_result_t r;
        int            s;
        logic          rev;
        logic          typ;
        longint        counts;
        longint        angle_q;
        longint        vel_q;
        r        = '0;
        r.status = mfmt_pkg::ST_IGNORED;
        if (ext || fid < mfmt_pkg::BASE_ID
            || fid >= mfmt_pkg::BASE_ID + mfmt_pkg::MOTOR_SLOTS)
            return r;
        s      = int'(fid - mfmt_pkg::BASE_ID);
        r.slot = mfmt_pkg::SLOT_W'(s);
        if (!present_m[s]) begin
            r.status = mfmt_pkg::ST_UNREG;
            return r;
        end
        if (op == mfmt_pkg::OP_ZERO) begin
            turn_cnt[s] = '0;
            zero_ang[s] = last_ang[s];
            r.status    = mfmt_pkg::ST_RESET;
            return r;
        end
        // wrap detection between the outer bands
        if (raw < mfmt_pkg::LOW_BAND && last_ang[s] > mfmt_pkg::HIGH_BAND)
            turn_cnt[s] = turn_cnt[s] + 1'b1;
        if (raw > mfmt_pkg::HIGH_BAND && last_ang[s] < mfmt_pkg::LOW_BAND)
            turn_cnt[s] = turn_cnt[s] - 1'b1;
        last_ang[s] = raw;
        if (frame_cnt[s] != mfmt_pkg::FCNT_MAX) frame_cnt[s] = frame_cnt[s] + 1'b1;
        rev    = reverse_m[s];
        typ    = type_m[s];
        counts = longint'($signed(turn_cnt[s])) * TURN_COUNTS + longint'(raw)
                 - longint'(zero_ang[s]);
        if (rev) counts = -counts;
        angle_q = round_saturate(counts * longint'(ang_scale[typ]), mfmt_pkg::ABS_W);
        vel_q   = round_saturate((rev ? -longint'(rpm) : longint'(rpm))
                                 * longint'(spd_scale[typ]), mfmt_pkg::VEL_W);
        if (frame_cnt[s] == mfmt_pkg::AZ_FRAME && autozero_m[s]) begin
            turn_cnt[s] = '0;
            zero_ang[s] = raw;
            angle_q     = 0;
        end
        r.status = mfmt_pkg::ST_UPDATED;
        r.angle  = angle_q[mfmt_pkg::ABS_W-1:0];
        r.vel    = vel_q[mfmt_pkg::VEL_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        shaft_result_t want;
        if (!aresetn) begin
            present_m    = '0;
            reverse_m    = '0;
            autozero_m   = '0;
            type_m       = '0;
            ang_scale[0] = mfmt_pkg::ANGLE_SCALE_ZERO_RST;
            ang_scale[1] = mfmt_pkg::ANGLE_SCALE_ONE_RST;
            spd_scale[0] = mfmt_pkg::SPEED_SCALE_ZERO_RST;
            spd_scale[1] = mfmt_pkg::SPEED_SCALE_ONE_RST;
            for (int i = 0; i < mfmt_pkg::MOTOR_SLOTS; i++) begin
                last_ang[i]  = '0;
                turn_cnt[i]  = '0;
                zero_ang[i]  = '0;
                frame_cnt[i] = '0;
            end
            shaft_results.delete();
            errs = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (mfmt_pkg::reg_idx_t'(paddr[mfmt_pkg::PADDR_W-1:2]))
                    mfmt_pkg::REG_PRESENT:    present_m    = pwdata[7:0];
                    mfmt_pkg::REG_REVERSE:    reverse_m    = pwdata[7:0];
                    mfmt_pkg::REG_HOME_MASK:  autozero_m   = pwdata[7:0];
                    mfmt_pkg::REG_TYPE:       type_m       = pwdata[7:0];
                    mfmt_pkg::REG_ANGLE_ZERO: ang_scale[0] = pwdata;
                    mfmt_pkg::REG_ANGLE_ONE:  ang_scale[1] = pwdata;
                    mfmt_pkg::REG_SPEED_ZERO: spd_scale[0] = pwdata;
                    mfmt_pkg::REG_SPEED_ONE:  spd_scale[1] = pwdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (shaft_results.size() == 0) begin
                    if (errs < 10)
                        $display("unexpected result: status %0d slot %0d angle %0d vel %0d",
                                 m_status, m_motor_slot, m_abs_angle, m_velocity);
                    errs++;
                end else begin
                    want = shaft_results.pop_front();
                    if (m_status !== want.status || m_motor_slot !== want.slot ||
                        m_abs_angle !== want.angle || m_velocity !== want.vel) begin
                        if (errs < 10) begin
                            $display("mismatch: expected status %0d slot %0d angle %0d vel %0d",
                                     want.status, want.slot, want.angle, want.vel);
                            $display("          got      status %0d slot %0d angle %0d vel %0d",
                                     m_status, m_motor_slot, m_abs_angle, m_velocity);
                        end
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready)
                shaft_results.push_back(track_frame(mfmt_pkg::op_t'(s_op), s_frame_id,
                                                    s_is_extended, s_angle_raw,
                                                    s_speed_rpm));
        end
        in_flight      <= shaft_results.size();
        mismatch_count <= errs;
    end

endmodule

### verif/testbench.sv
// Testbench top for the multi-turn tracker: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 1000;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid, s_ready;
    logic                                s_op;
    logic [mfmt_pkg::ID_W-1:0]           s_frame_id;
    logic                                s_is_extended;
    logic [mfmt_pkg::ANGLE_W-1:0]        s_angle_raw;
    logic signed [mfmt_pkg::RPM_W-1:0]   s_speed_rpm;
    logic                                m_valid, m_ready;
    logic [1:0]                          m_status;
    logic [mfmt_pkg::SLOT_W-1:0]         m_motor_slot;
    logic signed [mfmt_pkg::ABS_W-1:0]   m_abs_angle;
    logic signed [mfmt_pkg::VEL_W-1:0]   m_velocity;
    logic                                psel, penable, pwrite;
    logic [mfmt_pkg::PADDR_W-1:0]        paddr;
    logic [mfmt_pkg::PDATA_W-1:0]        pwdata;
    logic [mfmt_pkg::PDATA_W-1:0]        prdata;
    logic                                pready;

    int mismatch_count;
    int in_flight;
    int quiet_cycles = 0;
    int gap_pct      = 20;
    bit calm         = 1'b0;

    motor_feedback_multiturn_tracker_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_frame_id(s_frame_id),
        .s_is_extended(s_is_extended), .s_angle_raw(s_angle_raw), .s_speed_rpm(s_speed_rpm),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_motor_slot(m_motor_slot), .m_abs_angle(m_abs_angle), .m_velocity(m_velocity),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    multiturn_check u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_frame_id(s_frame_id),
        .s_is_extended(s_is_extended), .s_angle_raw(s_angle_raw), .s_speed_rpm(s_speed_rpm),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_motor_slot(m_motor_slot), .m_abs_angle(m_abs_angle), .m_velocity(m_velocity),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatch_count(mismatch_count), .in_flight(in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_frame(mfmt_pkg::op_t op, logic [mfmt_pkg::ID_W-1:0] fid, logic ext,
                              logic [mfmt_pkg::ANGLE_W-1:0] raw,
                              logic signed [mfmt_pkg::RPM_W-1:0] rpm);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_frame_id    <= fid;
        s_is_extended <= ext;
        s_angle_raw   <= raw;
        s_speed_rpm   <= rpm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic feed(int slot, logic [mfmt_pkg::ANGLE_W-1:0] raw,
                        logic signed [mfmt_pkg::RPM_W-1:0] rpm);
        send_frame(mfmt_pkg::OP_FEEDBACK, mfmt_pkg::BASE_ID + mfmt_pkg::ID_W'(slot), 1'b0,
                   raw, rpm);
    endtask

    // drop valid and wait until every item has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // psel stays up across back-to-back writes; lowered once at the end
    task automatic apb_write(mfmt_pkg::reg_idx_t idx, logic [mfmt_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic load_config(logic [7:0] pres, logic [7:0] rev, logic [7:0] az,
                               logic [7:0] typ, logic [31:0] as0, logic [31:0] as1,
                               logic [31:0] ss0, logic [31:0] ss1);
        apb_write(mfmt_pkg::REG_PRESENT, {24'd0, pres});
        apb_write(mfmt_pkg::REG_REVERSE, {24'd0, rev});
        apb_write(mfmt_pkg::REG_HOME_MASK, {24'd0, az});
        apb_write(mfmt_pkg::REG_TYPE, {24'd0, typ});
        apb_write(mfmt_pkg::REG_ANGLE_ZERO, as0);
        apb_write(mfmt_pkg::REG_ANGLE_ONE, as1);
        apb_write(mfmt_pkg::REG_SPEED_ZERO, ss0);
        apb_write(mfmt_pkg::REG_SPEED_ONE, ss1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // biased toward the wrap bands so turns get counted often
    function automatic logic [mfmt_pkg::ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return mfmt_pkg::ANGLE_W'($urandom_range(0, 2047));
            1: return mfmt_pkg::ANGLE_W'($urandom_range(6145, 8191));
            2: begin
                case ($urandom_range(0, 5))
                    0: return 13'd2047;
                    1: return 13'd2048;
                    2: return 13'd6144;
                    3: return 13'd6145;
                    4: return 13'd0;
                    default: return 13'd8191;
                endcase
            end
            3: return mfmt_pkg::ANGLE_W'($urandom_range(2048, 6144));
            default: return mfmt_pkg::ANGLE_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [mfmt_pkg::RPM_W-1:0] pick_rpm();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return mfmt_pkg::RPM_W'($urandom());
        endcase
    endfunction

    task automatic random_items(int n);
        int                          useful;
        int                          sent;
        logic [mfmt_pkg::ID_W-1:0]   fid;
        logic                        ext;
        mfmt_pkg::op_t               op;
        useful = 0;
        sent   = 0;
        while (useful < n) begin
            if (sent % 32 == 0) begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    2: gap_pct = 30;
                    default: gap_pct = 60;
                endcase
            end
            if ($urandom_range(0, 3) != 0) begin
                fid = mfmt_pkg::BASE_ID + mfmt_pkg::ID_W'($urandom_range(0, 7));
                ext = 1'b0;
                op  = ($urandom_range(0, 19) == 0) ? mfmt_pkg::OP_ZERO : mfmt_pkg::OP_FEEDBACK;
                useful++;
            end else begin
                // noise: half near the slot range, half anywhere
                fid = ($urandom_range(0, 1) == 0)
                      ? mfmt_pkg::BASE_ID - mfmt_pkg::ID_W'(2)
                        + mfmt_pkg::ID_W'($urandom_range(0, 12))
                      : mfmt_pkg::ID_W'($urandom());
                ext = 1'($urandom());
                op  = mfmt_pkg::op_t'($urandom_range(0, 1));
            end
            send_frame(op, fid, ext, pick_angle(), pick_rpm());
            sent++;
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_op          <= mfmt_pkg::OP_FEEDBACK;
        s_frame_id    <= '0;
        s_is_extended <= 1'b0;
        s_angle_raw   <= '0;
        s_speed_rpm   <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // nothing registered after reset
        feed(0, 13'd100, 16'sd50);
        settle();
        load_config(8'h7F, 8'hAA, 8'h04, 8'hCC,
                    mfmt_pkg::ANGLE_SCALE_ZERO_RST, mfmt_pkg::ANGLE_SCALE_ONE_RST,
                    mfmt_pkg::SPEED_SCALE_ZERO_RST, mfmt_pkg::SPEED_SCALE_ONE_RST);

        // ignored identifiers, both ops
        send_frame(mfmt_pkg::OP_FEEDBACK, mfmt_pkg::BASE_ID, 1'b1, 13'd1234, 16'sd10);
        send_frame(mfmt_pkg::OP_FEEDBACK, 11'h200, 1'b0, 13'd1234, 16'sd10);
        send_frame(mfmt_pkg::OP_FEEDBACK, 11'h209, 1'b0, 13'd1234, 16'sd10);
        send_frame(mfmt_pkg::OP_FEEDBACK, 11'h7FF, 1'b0, 13'h1FFF, 16'shFFFF);
        send_frame(mfmt_pkg::OP_FEEDBACK, 11'h000, 1'b0, 13'd0, 16'sd0);
        send_frame(mfmt_pkg::OP_ZERO, mfmt_pkg::BASE_ID + 11'd1, 1'b1, 13'd0, 16'sd0);
        // slot 7 not registered
        feed(7, 13'd500, 16'sd100);
        send_frame(mfmt_pkg::OP_ZERO, mfmt_pkg::BASE_ID + 11'd7, 1'b0, 13'd0, 16'sd0);
        // turn counting and band boundaries on slot 0
        feed(0, 13'd8191, 16'sh7FFF);
        feed(0, 13'd0, 16'sh8000);
        feed(0, 13'd8191, 16'sd0);
        feed(0, 13'd6144, 16'sd1);
        feed(0, 13'd0, 16'sd2);
        feed(0, 13'd6145, 16'shFFFF);
        feed(0, 13'd2047, 16'sd300);
        feed(0, 13'd2048, 16'sd300);
        feed(0, 13'd8191, 16'sd300);
        send_frame(mfmt_pkg::OP_ZERO, mfmt_pkg::BASE_ID, 1'b0, 13'd0, 16'sd0);
        feed(0, 13'd4000, 16'sd7);
        // reversed slots 1 and 3, both types, and unreversed slot 6
        feed(1, 13'd8000, 16'sh8000);
        feed(1, 13'd10, 16'sh7FFF);
        feed(3, 13'd5000, 16'sh8000);
        feed(6, 13'd7777, 16'sh7FFF);

        // spin slot 2 through many turns; auto-zero on the way
        settle();
        load_config(8'hFF, 8'h00, 8'h04, 8'h00, '1, '1, '1, '1);
        gap_pct = 10;
        for (int t = 0; t < 100; t++) begin
            feed(2, 13'd7000, pick_rpm());
            feed(2, 13'd1000, pick_rpm());
        end
        settle();
        load_config(8'hFF, 8'h04, 8'h00, 8'h00, '1, '1, '1, '1);
        feed(2, 13'd7000, 16'sh8000);
        feed(2, 13'd1000, 16'sh7FFF);
        feed(2, 13'd7000, 16'sh0001);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: load_config(8'hFF, 8'h00, 8'hFF, 8'h00, '1, '1, '1, '1);
                1: load_config(8'h00, 8'hFF, 8'h00, 8'hFF, '0, '0, '0, '0);
                2: load_config(8'hFF, 8'hFF, 8'h00, 8'hFF, '0, '1, '0, '1);
                3, 4: load_config(8'($urandom()) | 8'($urandom()), 8'($urandom()),
                                  8'($urandom()), 8'($urandom()),
                                  $urandom() >> $urandom_range(0, 31), $urandom(),
                                  $urandom() >> $urandom_range(0, 31), $urandom());
                default: begin
                    calm = 1'b1;
                    load_config(8'($urandom()) | 8'h0F, 8'($urandom()), 8'($urandom()),
                                8'($urandom()),
                                mfmt_pkg::ANGLE_SCALE_ZERO_RST,
                                mfmt_pkg::ANGLE_SCALE_ONE_RST,
                                mfmt_pkg::SPEED_SCALE_ZERO_RST,
                                mfmt_pkg::SPEED_SCALE_ONE_RST);
                end
            endcase
            random_items(ph == 1 ? 50 : 150);
        end

        settle();
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0 && in_flight == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
